// ===== hw/rtl/cts_pkg.sv =====
// ----------------------------------------------------------------------------
// cts_pkg: clip translate stack shared definitions
// stack depth, rectangle and offset types, opcodes, saturation helpers
// ----------------------------------------------------------------------------
package cts_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_DRAW = 2'd2
    } op_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic        [14:0] w;
        logic        [14:0] h;
    } rect_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
    } offset_t;

    // clamp a 17-bit signed sum to signed 16 bits
    function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
        if (v > 17'sd32767) begin
            return 16'sh7fff;
        end else if (v < -17'sd32768) begin
            return 16'sh8000;
        end else begin
            return v[15:0];
        end
    endfunction

    // clamp a 17-bit signed difference to unsigned 15 bits
    function automatic logic [14:0] sat15u(input logic signed [16:0] v);
        if (v < 17'sd0) begin
            return 15'd0;
        end else if (v > 17'sd32767) begin
            return 15'h7fff;
        end else begin
            return v[14:0];
        end
    endfunction

endpackage

// ===== hw/rtl/clip_translate_stack_top.sv =====
// ----------------------------------------------------------------------------
// clip_translate_stack_top: 2d clip rectangle stack with translation
// push, pop and draw requests against a stack of clip regions and offsets
// ----------------------------------------------------------------------------
// pipeline: input register, then result register, with the top-of-stack
//   read, add and clip between them
// throughput: one request per cycle while m_tready does not stall the
//   result register; set by the single-pass clip datapath and stack update
// reset: synchronous active-low aresetn empties the stack and drops both
//   pipeline registers; stack entries are not cleared, only entries below the
//   count are ever used
module clip_translate_stack_top (
    input  logic        aclk,
    input  logic        aresetn,
    // request side
    input  logic        s_tvalid,
    output logic        s_tready,
    // pos_x[15:0], pos_y[31:16], width[46:32], height[61:47],
    // shift_x[77:62], shift_y[93:78], zero[95:94]
    input  logic [95:0] s_tdata,
    // op[1:0]
    input  logic [1:0]  s_tuser,
    // result side
    output logic        m_tvalid,
    input  logic        m_tready,
    // origin_x[15:0], origin_y[31:16], clip_x[47:32], clip_y[63:48],
    // clip_w[78:64], clip_h[93:79], zero[95:94]
    output logic [95:0] m_tdata,
    // ok[0], overflow[1]
    output logic [1:0]  m_tuser
);

    import cts_pkg::*;

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    logic               in_valid_reg;
    logic [1:0]         in_op_reg;
    logic signed [15:0] in_pos_x_reg;
    logic signed [15:0] in_pos_y_reg;
    logic        [14:0] in_width_reg;
    logic        [14:0] in_height_reg;
    logic signed [15:0] in_shift_x_reg;
    logic signed [15:0] in_shift_y_reg;

    // result register
    logic               out_valid_reg;
    logic               out_ok_reg;
    logic               out_ovf_reg;
    logic signed [15:0] out_origin_x_reg;
    logic signed [15:0] out_origin_y_reg;
    logic signed [15:0] out_clip_x_reg;
    logic signed [15:0] out_clip_y_reg;
    logic        [14:0] out_clip_w_reg;
    logic        [14:0] out_clip_h_reg;

    // stack state
    rect_t              clip_mem [STACK_DEPTH];
    offset_t            off_mem  [STACK_DEPTH];
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    // the input register moves on whenever the result register is free or
    // being emptied this cycle, so while results are taken a new request can enter every cycle
    logic advance;
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg      <= s_tuser;
            in_pos_x_reg   <= s_tdata[15:0];
            in_pos_y_reg   <= s_tdata[31:16];
            in_width_reg   <= s_tdata[46:32];
            in_height_reg  <= s_tdata[61:47];
            in_shift_x_reg <= s_tdata[77:62];
            in_shift_y_reg <= s_tdata[93:78];
        end
    end

    // ------------------------------------------------------------------
    // top of stack
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] top_cnt;
    logic [IDX_W-1:0] top_idx;
    logic [IDX_W-1:0] wr_idx;
    logic             stack_empty;
    logic             stack_full;
    rect_t            top_clip;
    offset_t          top_off;
    offset_t          eff_off;

    assign top_cnt     = count_reg - CNT_W'(1);
    assign top_idx     = top_cnt[IDX_W-1:0];
    assign wr_idx      = count_reg[IDX_W-1:0];
    assign stack_empty = (count_reg == '0);
    assign stack_full  = (count_reg == CNT_W'(STACK_DEPTH));
    assign top_clip    = clip_mem[top_idx];
    assign top_off     = off_mem[top_idx];
    // an empty stack behaves as a zero offset
    assign eff_off     = stack_empty ? '0 : top_off;

    // ------------------------------------------------------------------
    // translate and intersect with the top clip
    // ------------------------------------------------------------------
    logic signed [15:0] moved_x;
    logic signed [15:0] moved_y;
    logic signed [15:0] a_right;
    logic signed [15:0] a_bottom;
    logic signed [15:0] b_right;
    logic signed [15:0] b_bottom;
    logic signed [15:0] isect_l;
    logic signed [15:0] isect_t;
    logic signed [15:0] isect_r;
    logic signed [15:0] isect_b;
    logic        [14:0] isect_w;
    logic        [14:0] isect_h;
    logic               hit;
    offset_t            new_off;
    rect_t              new_clip;

    assign moved_x  = sat16(17'(in_pos_x_reg) + 17'(eff_off.x));
    assign moved_y  = sat16(17'(in_pos_y_reg) + 17'(eff_off.y));
    assign a_right  = sat16(17'(moved_x) + 17'(in_width_reg));
    assign a_bottom = sat16(17'(moved_y) + 17'(in_height_reg));
    assign b_right  = sat16(17'(top_clip.x) + 17'(top_clip.w));
    assign b_bottom = sat16(17'(top_clip.y) + 17'(top_clip.h));

    assign isect_l  = (moved_x > top_clip.x) ? moved_x : top_clip.x;
    assign isect_t  = (moved_y > top_clip.y) ? moved_y : top_clip.y;
    assign isect_r  = (a_right < b_right) ? a_right : b_right;
    assign isect_b  = (a_bottom < b_bottom) ? a_bottom : b_bottom;
    assign hit      = (isect_r > isect_l) && (isect_b > isect_t);
    assign isect_w  = sat15u(17'(isect_r) - 17'(isect_l));
    assign isect_h  = sat15u(17'(isect_b) - 17'(isect_t));

    // accumulated offset for a pushed region; on an empty stack the zero
    // offset leaves the shift unchanged
    assign new_off.x = sat16(17'(in_shift_x_reg) + 17'(eff_off.x));
    assign new_off.y = sat16(17'(in_shift_y_reg) + 17'(eff_off.y));

    // a push onto an empty stack stores its rectangle unchanged
    always_comb begin
        if (stack_empty) begin
            new_clip = '{x: in_pos_x_reg, y: in_pos_y_reg,
                         w: in_width_reg, h: in_height_reg};
        end else begin
            new_clip = '{x: isect_l, y: isect_t, w: isect_w, h: isect_h};
        end
    end

    // ------------------------------------------------------------------
    // request decode
    // ------------------------------------------------------------------
    logic               push_we;
    logic               ok_next;
    logic               ovf_next;
    logic signed [15:0] origin_x_next;
    logic signed [15:0] origin_y_next;
    logic signed [15:0] clip_x_next;
    logic signed [15:0] clip_y_next;
    logic        [14:0] clip_w_next;
    logic        [14:0] clip_h_next;

    always_comb begin
        push_we       = 1'b0;
        count_next    = count_reg;
        ok_next       = 1'b0;
        ovf_next      = 1'b0;
        origin_x_next = '0;
        origin_y_next = '0;
        clip_x_next   = '0;
        clip_y_next   = '0;
        clip_w_next   = '0;
        clip_h_next   = '0;
        case (op_t'(in_op_reg))
            OP_PUSH: begin
                if (stack_full) begin
                    ovf_next = 1'b1;
                end else if (stack_empty || hit) begin
                    push_we    = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    ok_next    = 1'b1;
                end
            end
            OP_POP: begin
                ok_next = 1'b1;
                if (!stack_empty) begin
                    count_next = top_cnt;
                end
            end
            OP_DRAW: begin
                origin_x_next = moved_x;
                origin_y_next = moved_y;
                // no region: the rectangle passes through as drawn
                if (stack_empty) begin
                    ok_next     = 1'b1;
                    clip_x_next = in_pos_x_reg;
                    clip_y_next = in_pos_y_reg;
                    clip_w_next = in_width_reg;
                    clip_h_next = in_height_reg;
                end else if (hit) begin
                    ok_next     = 1'b1;
                    clip_x_next = isect_l;
                    clip_y_next = isect_t;
                    clip_w_next = isect_w;
                    clip_h_next = isect_h;
                end
            end
            default: begin
                // unused opcode: no state change, all-zero result
            end
        endcase
    end

    // ------------------------------------------------------------------
    // stack update
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (advance) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && push_we) begin
            clip_mem[wr_idx] <= new_clip;
            off_mem[wr_idx]  <= new_off;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_ok_reg       <= ok_next;
            out_ovf_reg      <= ovf_next;
            out_origin_x_reg <= origin_x_next;
            out_origin_y_reg <= origin_y_next;
            out_clip_x_reg   <= clip_x_next;
            out_clip_y_reg   <= clip_y_next;
            out_clip_w_reg   <= clip_w_next;
            out_clip_h_reg   <= clip_h_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {out_ovf_reg, out_ok_reg};
    assign m_tdata  = {2'b00, out_clip_h_reg, out_clip_w_reg,
                       out_clip_y_reg, out_clip_x_reg,
                       out_origin_y_reg, out_origin_x_reg};

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
`ifndef SYNTH
    // the stack never holds more entries than it has room for
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // a refused push on a full stack leaves the stack untouched
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (in_op_reg == OP_PUSH) && stack_full)
        |=> (count_reg == $past(count_reg)))
        else $error("full push changed the stack");

    // overflow is never reported alongside an accepted push
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("ok and overflow both set");

    // a held request is not lost while the result side stalls
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_tready) |=> in_valid_reg)
        else $error("pending request dropped under stall");
`endif

endmodule

// ===== verif/clip_stack_check_pkg.sv =====
// ----------------------------------------------------------------------------
// clip_stack_check_pkg: scoreboard for the clip translate stack
// tracks its own copy of the region stack, predicts every result and checks
// the returned results in order
// ----------------------------------------------------------------------------
package clip_stack_check_pkg;

    import cts_pkg::*;

    // laid out exactly as {s_tuser, s_tdata[93:0]}
    typedef struct packed {
        op_t                op;
        logic signed [15:0] shift_y;
        logic signed [15:0] shift_x;
        logic        [14:0] height;
        logic        [14:0] width;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_x;
    } clip_req_t;

    typedef struct packed {
        logic               ok;
        logic               overflow;
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic signed [15:0] clip_x;
        logic signed [15:0] clip_y;
        logic        [14:0] clip_w;
        logic        [14:0] clip_h;
    } clip_result_t;

    class clip_stack_scoreboard;

        typedef struct {
            int x;
            int y;
            int w;
            int h;
        } area_t;

        area_t        region_mem[STACK_DEPTH];
        int           shift_mem_x[STACK_DEPTH];
        int           shift_mem_y[STACK_DEPTH];
        int           region_count;
        clip_result_t expected_q[$];
        int unsigned  result_index;
        int unsigned  fail_count;

        function new();
            region_count = 0;
            result_index = 0;
            fail_count   = 0;
        endfunction

        function int clamp_s16(int v);
            if (v > 32767) begin
                return 32767;
            end else if (v < -32768) begin
                return -32768;
            end
            return v;
        endfunction

        function int clamp_u15(int v);
            if (v > 32767) begin
                return 32767;
            end else if (v < 0) begin
                return 0;
            end
            return v;
        endfunction

        // max of the near edges, min of the saturated far edges
        function bit overlap(input area_t a, input area_t b, output area_t o);
            int l, t, ra, rb, ba, bb, r, bo;
            l  = (a.x > b.x) ? a.x : b.x;
            t  = (a.y > b.y) ? a.y : b.y;
            ra = clamp_s16(a.x + a.w);
            rb = clamp_s16(b.x + b.w);
            ba = clamp_s16(a.y + a.h);
            bb = clamp_s16(b.y + b.h);
            r  = (ra < rb) ? ra : rb;
            bo = (ba < bb) ? ba : bb;
            o  = '{default: 0};
            if (r <= l || bo <= t) begin
                return 1'b0;
            end
            o.x = l;
            o.y = t;
            o.w = clamp_u15(r - l);
            o.h = clamp_u15(bo - t);
            return 1'b1;
        endfunction

        function void note_request(clip_req_t rq);
            clip_result_t res;
            area_t        r, c;
            int           tx, ty, top;
            bit           seen;
            res  = '0;
            r.x  = int'(rq.pos_x);
            r.y  = int'(rq.pos_y);
            r.w  = int'(rq.width);
            r.h  = int'(rq.height);
            tx   = int'(rq.shift_x);
            ty   = int'(rq.shift_y);
            top  = region_count - 1;
            seen = 1'b0;
            case (rq.op)
                OP_PUSH: begin
                    if (region_count >= STACK_DEPTH) begin
                        res.overflow = 1'b1;
                    end else if (region_count == 0) begin
                        region_mem[0]  = r;
                        shift_mem_x[0] = tx;
                        shift_mem_y[0] = ty;
                        region_count   = 1;
                        res.ok         = 1'b1;
                    end else begin
                        r.x = clamp_s16(r.x + shift_mem_x[top]);
                        r.y = clamp_s16(r.y + shift_mem_y[top]);
                        if (overlap(r, region_mem[top], c)) begin
                            region_mem[region_count]  = c;
                            shift_mem_x[region_count] = clamp_s16(tx + shift_mem_x[top]);
                            shift_mem_y[region_count] = clamp_s16(ty + shift_mem_y[top]);
                            region_count++;
                            res.ok = 1'b1;
                        end
                    end
                end
                OP_POP: begin
                    if (region_count > 0) begin
                        region_count--;
                    end
                    res.ok = 1'b1;
                end
                OP_DRAW: begin
                    if (region_count == 0) begin
                        c    = r;
                        seen = 1'b1;
                    end else begin
                        r.x  = clamp_s16(r.x + shift_mem_x[top]);
                        r.y  = clamp_s16(r.y + shift_mem_y[top]);
                        seen = overlap(r, region_mem[top], c);
                    end
                    res.origin_x = 16'(r.x);
                    res.origin_y = 16'(r.y);
                    if (seen) begin
                        res.ok     = 1'b1;
                        res.clip_x = 16'(c.x);
                        res.clip_y = 16'(c.y);
                        res.clip_w = 15'(c.w);
                        res.clip_h = 15'(c.h);
                    end
                end
                default: ;
            endcase
            expected_q.push_back(res);
        endfunction

        task report(string msg);
            $display("mismatch at result %0d: %s", result_index, msg);
            fail_count++;
        endtask

        task compare(string field, int got, int want);
            if (got != want) begin
                report($sformatf("%s got %0d expected %0d", field, got, want));
            end
        endtask

        task check_result(logic [95:0] data, logic [1:0] user);
            clip_result_t want;
            if (expected_q.size() == 0) begin
                report("result with nothing expected");
                result_index++;
                return;
            end
            want = expected_q.pop_front();
            compare("ok", user[0], want.ok);
            compare("overflow", user[1], want.overflow);
            compare("origin_x", $signed(data[15:0]), want.origin_x);
            compare("origin_y", $signed(data[31:16]), want.origin_y);
            compare("clip_x", $signed(data[47:32]), want.clip_x);
            compare("clip_y", $signed(data[63:48]), want.clip_y);
            compare("clip_w", data[78:64], want.clip_w);
            compare("clip_h", data[93:79], want.clip_h);
            result_index++;
        endtask

        function int pending();
            return expected_q.size();
        endfunction

        task flag_leftovers();
            while (expected_q.size() > 0) begin
                void'(expected_q.pop_front());
                report("expected result never arrived");
                result_index++;
            end
        endtask

    endclass

endpackage

// ===== verif/clip_translate_stack_top_test.sv =====
// ----------------------------------------------------------------------------
// clip_translate_stack_top_test: self-checking bench for the clip stack
// a directed run over the corner cases (empty stack, full stack, empty
// intersections, saturating edges) then a long random run of push, pop and
// draw requests with random idling on both sides and one long result stall
// ----------------------------------------------------------------------------
module clip_translate_stack_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import cts_pkg::*;
    import clip_stack_check_pkg::*;

    localparam int RANDOM_REQUESTS = 1750;
    localparam int STALL_LIMIT     = 2000;  // cycles with no handshake at all
    localparam int LONG_HOLD       = 300;   // long result-side hold-off
    localparam int DRAIN_CYCLES    = 8;     // two-stage pipe plus margin

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // pos_x[15:0], pos_y[31:16], width[46:32], height[61:47],
    // shift_x[77:62], shift_y[93:78], zero[95:94]
    logic [95:0] s_tdata  = '0;
    // op[1:0]
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // origin_x[15:0], origin_y[31:16], clip_x[47:32], clip_y[63:48],
    // clip_w[78:64], clip_h[93:79], zero[95:94]
    logic [95:0] m_tdata;
    // ok[0], overflow[1]
    logic [1:0]  m_tuser;

    clip_stack_scoreboard sb = new();

    // pacing controls for the request and result sides, and the watchdog count
    bit          tx_no_idle    = 1'b0;
    bit          rx_no_idle    = 1'b0;
    bit          long_hold_due = 1'b0;
    int unsigned quiet_cycles  = 0;

    clip_translate_stack_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // both channels are observed at the rising edge only; requests are
    // noted before results so a same-edge pair can never be misordered
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note_request(clip_req_t'({s_tuser, s_tdata[93:0]}));
            end
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata, m_tuser);
            end
        end
    end

    // watchdog: any handshake on either side counts as progress
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("FAIL clip_translate_stack_top");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic clip_req_t build_request(op_t op, int px, int py, int w, int h,
                                                int sx, int sy);
        clip_req_t rq;
        rq.op      = op;
        rq.pos_x   = 16'(px);
        rq.pos_y   = 16'(py);
        rq.width   = 15'(w);
        rq.height  = 15'(h);
        rq.shift_x = 16'(sx);
        rq.shift_y = 16'(sy);
        return rq;
    endfunction

    // values at and next to the saturation points
    function automatic int edge_value(bit is_size);
        int unsigned k;
        k = $urandom_range(0, 5);
        if (is_size) begin
            case (k)
                0, 1:    return 0;
                2:       return 1;
                3:       return 32766;
                default: return 32767;
            endcase
        end
        case (k)
            0:       return -32768;
            1:       return -32767;
            2:       return -1;
            3:       return 0;
            4:       return 32766;
            default: return 32767;
        endcase
    endfunction

    // mostly small nested regions so pushes tend to stick and draws land,
    // with some full-range noise and some edge-value requests
    function automatic clip_req_t random_request(op_t op);
        int unsigned mode;
        mode = $urandom_range(0, 15);
        if (mode < 2) begin
            return build_request(op, $urandom, $urandom, $urandom, $urandom,
                                 $urandom, $urandom);
        end else if (mode == 2) begin
            return build_request(op, edge_value(0), edge_value(0), edge_value(1),
                                 edge_value(1), edge_value(0), edge_value(0));
        end
        return build_request(op, int'($urandom_range(0, 400)) - 200,
                             int'($urandom_range(0, 400)) - 200,
                             $urandom_range(0, 300), $urandom_range(0, 300),
                             int'($urandom_range(0, 60)) - 30,
                             int'($urandom_range(0, 60)) - 30);
    endfunction

    // offer one request after a random gap and hold it until accepted
    task automatic send_request(clip_req_t rq);
        int unsigned gap;
        gap = tx_no_idle ? 0 : $urandom_range(0, 7);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, rq[93:0]};
        s_tuser  <= rq.op;
        do @(posedge aclk); while (!s_tready);
    endtask

    // result side: random stall per result, with the odd long hold-off
    initial begin : result_sink
        int unsigned stall;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (long_hold_due) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                long_hold_due = 1'b0;
            end else begin
                stall = rx_no_idle ? 0 : $urandom_range(0, 7);
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(negedge aclk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            if ($urandom_range(0, 31) == 0) begin
                rx_no_idle = !rx_no_idle;
            end
        end
    end

    initial begin : stimulus
        op_t         op;
        int unsigned n, pick;
        bit          filling;

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        // empty stack: pop does nothing, draw passes the rectangle through
        send_request(build_request(OP_POP, 0, 0, 0, 0, 0, 0));
        send_request(build_request(OP_DRAW, -32768, 32767, 32767, 0, 32767, -32768));
        // zero-size region is still taken on an empty stack
        send_request(build_request(OP_PUSH, 0, 0, 0, 0, 0, 0));
        // nothing can be visible through a zero-size region
        send_request(build_request(OP_DRAW, 5, 5, 10, 10, 0, 0));
        send_request(build_request(OP_PUSH, 0, 0, 10, 10, 1, 1));
        send_request(build_request(OP_POP, 0, 0, 0, 0, 0, 0));
        // widest region, then a nested one with extreme shifts
        send_request(build_request(OP_PUSH, -32768, -32768, 32767, 32767, 0, 0));
        send_request(build_request(OP_PUSH, -5000, -5000, 32767, 32767, 32767, -32768));
        // extreme positions cancel the extreme shifts, origin -1 on both axes
        send_request(build_request(OP_DRAW, -32768, 32767, 32767, 32767, 0, 0));
        send_request(build_request(OP_POP, 0, 0, 0, 0, 0, 0));
        send_request(build_request(OP_DRAW, -6000, -100, 3000, 50, 0, 0));
        // fill the stack, then one push too many
        for (n = 0; n < 15; n++) begin
            send_request(build_request(OP_PUSH, -1000, -1000, 2000, 2000, 3, -3));
        end
        send_request(build_request(OP_PUSH, 0, 0, 100, 100, 0, 0));
        send_request(build_request(OP_DRAW, 0, 0, 50, 50, 0, 0));

        // random run alternating between filling and draining phases
        filling = 1'b1;
        for (n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n == 100) begin
                // back-to-back requests against a stalled result side
                long_hold_due = 1'b1;
                tx_no_idle    = 1'b1;
            end else if (n == 180) begin
                tx_no_idle = 1'b0;
            end else if (n > 180 && $urandom_range(0, 49) == 0) begin
                tx_no_idle = !tx_no_idle;
            end
            if ($urandom_range(0, 39) == 0) begin
                filling = !filling;
            end
            pick = $urandom_range(0, 99);
            if (filling) begin
                if (pick < 55) begin
                    op = OP_PUSH;
                end else if (pick < 90) begin
                    op = OP_DRAW;
                end else begin
                    op = OP_POP;
                end
            end else begin
                if (pick < 15) begin
                    op = OP_PUSH;
                end else if (pick < 55) begin
                    op = OP_DRAW;
                end else begin
                    op = OP_POP;
                end
            end
            send_request(random_request(op));
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        sb.flag_leftovers();
        if (sb.fail_count == 0) begin
            $display("PASS clip_translate_stack_top");
        end else begin
            $display("FAIL clip_translate_stack_top");
        end
        $finish;
    end

endmodule
